// ===== rtl/sbsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbsc_pkg;

   localparam int unsigned QUOT_W     = 12;
   localparam int unsigned POS_W      = 13;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LEFT        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_TOP         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_WIDTH       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_HEIGHT      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_STEP       = 3'd6;

   localparam logic [7:0]  RST_PIXEL_THRESHOLD = 8'd200;
   localparam logic [11:0] RST_FRAME_WIDTH     = 12'd2048;
   localparam logic [10:0] RST_BOX_LEFT        = 11'd0;
   localparam logic [10:0] RST_BOX_TOP         = 11'd0;
   localparam logic [11:0] RST_BOX_WIDTH       = 12'd100;
   localparam logic [11:0] RST_BOX_HEIGHT      = 12'd1280;
   localparam logic [11:0] RST_SCAN_STEP       = 12'd20;

   typedef struct packed {
      logic [7:0] pixel;
      logic       end_of_frame;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [10:0] spot_x;
      logic [10:0] spot_y;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  pixel_threshold;
      logic [11:0] frame_width;
      logic [10:0] box_left;
      logic [10:0] box_top;
      logic [11:0] box_width;
      logic [11:0] box_height;
      logic [11:0] scan_step;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FLUSH,
      ST_SEARCH,
      ST_DIV_X,
      ST_DIV_Y,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      SR_IDLE,
      SR_CHECK,
      SR_READ,
      SR_DRAIN,
      SR_EVAL
   } search_state_type;

endpackage

`default_nettype wire

// ===== rtl/spot_box_search_centroid.sv =====
// Finds a bright spot in one 8-bit gray frame. Pixels are taken one per clock in raster
// order while busy is low; each pixel in the box rows is added into a per-column weight
// and row-moment memory through a read-modify-write pipeline with forwarding. The
// transfer with end_of_frame set is followed by a flush state and the box search, which
// reads one column per cycle; then come two divisions when a spot is found, one result
// strobe, and a clearing pass over the column memory. The same clearing pass runs after
// reset. busy stays high from the end-of-frame transfer until the clearing pass completes.
// The result is presented on rsp_data for exactly one cycle with rsp_valid high and
// cannot be held off.
`timescale 1ns / 1ps
`default_nettype none

module spot_box_search_centroid #(
   parameter int unsigned MAX_COLS = 2048,
   parameter int unsigned MAX_ROWS = 2048
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire sbsc_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   output sbsc_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [sbsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [sbsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned AW     = $clog2(MAX_COLS);
   localparam int unsigned RW     = $clog2(MAX_ROWS);
   localparam int unsigned WSUM_W = RW + 8;
   localparam int unsigned MOM_W  = 2 * RW + 8;
   localparam int unsigned MEM_W  = WSUM_W + MOM_W;
   localparam int unsigned DEN_W  = WSUM_W + 12;
   localparam int unsigned NX_W   = WSUM_W + 24;
   localparam int unsigned NY_W   = MOM_W + 12;
   localparam int unsigned DIV_W  = (NX_W > NY_W) ? NX_W : NY_W;
   localparam int unsigned PW     = sbsc_pkg::POS_W;
   localparam int unsigned QW     = sbsc_pkg::QUOT_W;

   sbsc_pkg::state_type state_ff, state_in;
   sbsc_pkg::cfg_type   cfg_ff;

   logic [11:0]       fw_eff;
   logic              accept;
   logic [AW-1:0]     col_ff;
   logic [RW:0]       row_ff;
   logic [13:0]       row_x;
   logic [13:0]       top_x;
   logic              in_box;
   logic [7:0]        p_kept;
   logic [RW-1:0]     dy;

   logic              s1_valid_ff;
   logic [AW-1:0]     s1_addr_ff;
   logic [7:0]        s1_p_ff;
   logic [MOM_W-1:0]  s1_mom_ff;
   logic              wv_ff;
   logic [AW-1:0]     wa_ff;
   logic [MEM_W-1:0]  wd_ff;
   logic [MEM_W-1:0]  base;
   logic [MEM_W-1:0]  pix_wdata;

   logic [AW-1:0]     clr_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [MEM_W-1:0]  mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [MEM_W-1:0]  mem_rdata;

   logic              srch_start;
   logic [AW-1:0]     srch_addr;
   logic              srch_done;
   logic              srch_hit;
   logic [PW-1:0]     srch_chosen;
   logic [NX_W-1:0]   srch_nx;
   logic [NY_W-1:0]   srch_ny;
   logic [DEN_W-1:0]  srch_den;

   logic              div_start;
   logic [DIV_W-1:0]  div_dividend;
   logic              div_done;
   logic [QW-1:0]     div_q;

   logic              found_ff;
   logic [QW-1:0]     qx_ff;
   logic [QW-1:0]     qy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_threshold <= sbsc_pkg::RST_PIXEL_THRESHOLD;
         cfg_ff.frame_width     <= sbsc_pkg::RST_FRAME_WIDTH;
         cfg_ff.box_left        <= sbsc_pkg::RST_BOX_LEFT;
         cfg_ff.box_top         <= sbsc_pkg::RST_BOX_TOP;
         cfg_ff.box_width       <= sbsc_pkg::RST_BOX_WIDTH;
         cfg_ff.box_height      <= sbsc_pkg::RST_BOX_HEIGHT;
         cfg_ff.scan_step       <= sbsc_pkg::RST_SCAN_STEP;
      end else if (csr_we) begin
         unique case (csr_index)
            sbsc_pkg::CSR_PIXEL_THRESHOLD: cfg_ff.pixel_threshold <= csr_wdata[7:0];
            sbsc_pkg::CSR_FRAME_WIDTH:     cfg_ff.frame_width     <= csr_wdata;
            sbsc_pkg::CSR_BOX_LEFT:        cfg_ff.box_left        <= csr_wdata[10:0];
            sbsc_pkg::CSR_BOX_TOP:         cfg_ff.box_top         <= csr_wdata[10:0];
            sbsc_pkg::CSR_BOX_WIDTH:       cfg_ff.box_width       <= csr_wdata;
            sbsc_pkg::CSR_BOX_HEIGHT:      cfg_ff.box_height      <= csr_wdata;
            sbsc_pkg::CSR_SCAN_STEP:       cfg_ff.scan_step       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (cfg_ff.frame_width == '0) begin
         fw_eff = 12'd1;
      end else if (32'(cfg_ff.frame_width) > MAX_COLS) begin
         fw_eff = 12'(MAX_COLS);
      end else begin
         fw_eff = cfg_ff.frame_width;
      end
   end

   assign accept = start && !busy;
   assign row_x  = 14'(row_ff);
   assign top_x  = 14'(cfg_ff.box_top);
   assign in_box = !row_ff[RW] && (row_x >= top_x) &&
                   (row_x < top_x + 14'(cfg_ff.box_height));
   assign p_kept = (req_data.pixel > cfg_ff.pixel_threshold) ? req_data.pixel : 8'd0;
   assign dy     = RW'(row_x - top_x);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         wv_ff       <= 1'b0;
      end else begin
         s1_valid_ff <= accept && in_box;
         wv_ff       <= s1_valid_ff;
         if (accept) begin
            if (req_data.end_of_frame) begin
               col_ff <= '0;
               row_ff <= '0;
            end else if (14'(col_ff) + 14'd1 >= 14'(fw_eff)) begin
               col_ff <= '0;
               if (!row_ff[RW]) begin
                  row_ff <= row_ff + 1'b1;
               end
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= col_ff;
      s1_p_ff    <= p_kept;
      s1_mom_ff  <= MOM_W'(dy) * MOM_W'(p_kept);
      wa_ff      <= s1_addr_ff;
      wd_ff      <= pix_wdata;
   end

   always_comb begin
      base = (wv_ff && wa_ff == s1_addr_ff) ? wd_ff : mem_rdata;
      pix_wdata = {base[MEM_W-1:WSUM_W] + s1_mom_ff,
                   base[WSUM_W-1:0] + WSUM_W'(s1_p_ff)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (state_ff == sbsc_pkg::ST_CLEAR) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   sbsc_colmem #(
      .AW (AW),
      .DW (MEM_W)
   ) u_colmem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   sbsc_search #(
      .AW     (AW),
      .WSUM_W (WSUM_W),
      .MOM_W  (MOM_W),
      .DEN_W  (DEN_W),
      .NX_W   (NX_W),
      .NY_W   (NY_W)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .start     (srch_start),
      .cfg       (cfg_ff),
      .fw_eff    (fw_eff),
      .rd_addr   (srch_addr),
      .rd_weight (mem_rdata[WSUM_W-1:0]),
      .rd_moment (mem_rdata[MEM_W-1:WSUM_W]),
      .done      (srch_done),
      .hit       (srch_hit),
      .chosen    (srch_chosen),
      .nx        (srch_nx),
      .ny        (srch_ny),
      .den       (srch_den)
   );

   sbsc_div #(
      .DW (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (DIV_W'(srch_den)),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbsc_pkg::ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = sbsc_pkg::ST_IDLE;
            end
         end
         sbsc_pkg::ST_IDLE: begin
            if (accept && req_data.end_of_frame) begin
               state_in = sbsc_pkg::ST_FLUSH;
            end
         end
         sbsc_pkg::ST_FLUSH: state_in = sbsc_pkg::ST_SEARCH;
         sbsc_pkg::ST_SEARCH: begin
            if (srch_done) begin
               state_in = srch_hit ? sbsc_pkg::ST_DIV_X : sbsc_pkg::ST_EMIT;
            end
         end
         sbsc_pkg::ST_DIV_X: begin
            if (div_done) begin
               state_in = sbsc_pkg::ST_DIV_Y;
            end
         end
         sbsc_pkg::ST_DIV_Y: begin
            if (div_done) begin
               state_in = sbsc_pkg::ST_EMIT;
            end
         end
         sbsc_pkg::ST_EMIT: state_in = sbsc_pkg::ST_CLEAR;
         default: state_in = sbsc_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      busy         = (state_ff != sbsc_pkg::ST_IDLE);
      rsp_valid    = (state_ff == sbsc_pkg::ST_EMIT);
      srch_start   = (state_ff == sbsc_pkg::ST_FLUSH);
      div_start    = 1'b0;
      div_dividend = DIV_W'(srch_ny);
      mem_raddr    = col_ff;
      mem_we       = s1_valid_ff;
      mem_waddr    = s1_addr_ff;
      mem_wdata    = pix_wdata;
      unique case (state_ff)
         sbsc_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         sbsc_pkg::ST_SEARCH: begin
            mem_raddr    = srch_addr;
            div_start    = srch_done && srch_hit;
            div_dividend = DIV_W'(srch_nx);
         end
         sbsc_pkg::ST_DIV_X: begin
            div_start = div_done;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbsc_pkg::ST_CLEAR;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == sbsc_pkg::ST_SEARCH && srch_done) begin
            found_ff <= srch_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sbsc_pkg::ST_DIV_X && div_done) begin
         qx_ff <= div_q;
      end
      if (state_ff == sbsc_pkg::ST_DIV_Y && div_done) begin
         qy_ff <= div_q;
      end
   end

   always_comb begin
      rsp_data.found  = found_ff;
      rsp_data.spot_x = found_ff ? 11'(srch_chosen + PW'(qx_ff)) : 11'd0;
      rsp_data.spot_y = found_ff ? 11'(cfg_ff.box_top + 11'(qy_ff)) : 11'd0;
   end

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result strobe while idle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbsc_pkg::ST_SEARCH) |-> !mem_we)
      else $error("column memory written during box search");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbsc_pkg::ST_FLUSH) |-> $past(accept && req_data.end_of_frame))
      else $error("search started without an end-of-frame transfer");

endmodule

`default_nettype wire

// ===== rtl/sbsc_colmem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbsc_colmem #(
   parameter int unsigned AW = 11,
   parameter int unsigned DW = 49
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/sbsc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbsc_div #(
   parameter int unsigned DW = 43
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [DW-1:0]               dividend,
   input  wire logic [DW-1:0]               divisor,
   output logic                             done,
   output logic [sbsc_pkg::QUOT_W-1:0]      quotient
);

   localparam int unsigned QW    = sbsc_pkg::QUOT_W;
   localparam int unsigned CNT_W = $clog2(QW);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DW-1:0]    rem_ff;
   logic [DW-1:0]    dsh_ff;
   logic [QW-1:0]    q_ff;
   logic             fits;

   assign fits = rem_ff >= dsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         dsh_ff <= divisor << (QW - 1);
         cnt_ff <= CNT_W'(QW - 1);
         q_ff   <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         q_ff   <= {q_ff[QW-2:0], fits};
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// ===== rtl/sbsc_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbsc_search #(
   parameter int unsigned AW     = 11,
   parameter int unsigned WSUM_W = 19,
   parameter int unsigned MOM_W  = 30,
   parameter int unsigned DEN_W  = 31,
   parameter int unsigned NX_W   = 43,
   parameter int unsigned NY_W   = 42
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire sbsc_pkg::cfg_type            cfg,
   input  wire logic [11:0]                  fw_eff,
   output logic      [AW-1:0]                rd_addr,
   input  wire logic [WSUM_W-1:0]            rd_weight,
   input  wire logic [MOM_W-1:0]             rd_moment,
   output logic                              done,
   output logic                              hit,
   output logic      [sbsc_pkg::POS_W-1:0]   chosen,
   output logic      [NX_W-1:0]              nx,
   output logic      [NY_W-1:0]              ny,
   output logic      [DEN_W-1:0]             den
);

   localparam int unsigned PW     = sbsc_pkg::POS_W;
   localparam int unsigned PROD_W = WSUM_W + 12;

   sbsc_pkg::search_state_type state_ff, state_in;

   logic [PW-1:0]     u_ff;
   logic [11:0]       c_ff;
   logic              a_valid_ff;
   logic [11:0]       a_c_ff;
   logic              b_valid_ff;
   logic [WSUM_W-1:0] b_w_ff;
   logic [MOM_W-1:0]  b_m_ff;
   logic [PROD_W-1:0] b_prod_ff;
   logic [DEN_W-1:0]  s_ff;
   logic [NX_W-1:0]   nxa_ff;
   logic [NY_W-1:0]   nya_ff;
   logic [DEN_W-1:0]  best_ff;
   logic [PW-1:0]     chosen_ff;
   logic [NX_W-1:0]   nx_ff;
   logic [NY_W-1:0]   ny_ff;
   logic              have_ff;
   logic              fit;
   logic              drop;
   logic [11:0]       step_eff;

   assign fit      = ({1'b0, u_ff} + 14'(cfg.box_width)) < 14'(fw_eff);
   assign drop     = s_ff < best_ff;
   assign step_eff = (cfg.scan_step == '0) ? 12'd1 : cfg.scan_step;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbsc_pkg::SR_IDLE: begin
            if (start) begin
               state_in = sbsc_pkg::SR_CHECK;
            end
         end
         sbsc_pkg::SR_CHECK: begin
            if (!fit) begin
               state_in = sbsc_pkg::SR_IDLE;
            end else if (cfg.box_width == '0) begin
               state_in = sbsc_pkg::SR_DRAIN;
            end else begin
               state_in = sbsc_pkg::SR_READ;
            end
         end
         sbsc_pkg::SR_READ: begin
            if (c_ff == cfg.box_width - 12'd1) begin
               state_in = sbsc_pkg::SR_DRAIN;
            end
         end
         sbsc_pkg::SR_DRAIN: begin
            if (!a_valid_ff && !b_valid_ff) begin
               state_in = sbsc_pkg::SR_EVAL;
            end
         end
         sbsc_pkg::SR_EVAL: begin
            state_in = drop ? sbsc_pkg::SR_IDLE : sbsc_pkg::SR_CHECK;
         end
         default: state_in = sbsc_pkg::SR_IDLE;
      endcase
   end

   always_comb begin
      rd_addr = AW'(u_ff + PW'(c_ff));
      done    = 1'b0;
      unique case (state_ff)
         sbsc_pkg::SR_CHECK: done = !fit;
         sbsc_pkg::SR_EVAL:  done = drop;
         default:            done = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sbsc_pkg::SR_IDLE;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         have_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         a_valid_ff <= (state_ff == sbsc_pkg::SR_READ);
         b_valid_ff <= a_valid_ff;
         if (state_ff == sbsc_pkg::SR_IDLE && start) begin
            have_ff <= 1'b0;
         end else if (state_ff == sbsc_pkg::SR_EVAL && !drop) begin
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_c_ff    <= c_ff;
      b_w_ff    <= rd_weight;
      b_m_ff    <= rd_moment;
      b_prod_ff <= PROD_W'(a_c_ff) * PROD_W'(rd_weight);
      if (b_valid_ff) begin
         s_ff   <= s_ff + DEN_W'(b_w_ff);
         nxa_ff <= nxa_ff + NX_W'(b_prod_ff);
         nya_ff <= nya_ff + NY_W'(b_m_ff);
      end
      case (state_ff)
         sbsc_pkg::SR_IDLE: begin
            if (start) begin
               u_ff    <= PW'(cfg.box_left);
               best_ff <= '0;
            end
         end
         sbsc_pkg::SR_CHECK: begin
            c_ff   <= '0;
            s_ff   <= '0;
            nxa_ff <= '0;
            nya_ff <= '0;
         end
         sbsc_pkg::SR_READ: begin
            c_ff <= c_ff + 12'd1;
         end
         sbsc_pkg::SR_EVAL: begin
            if (!drop) begin
               best_ff   <= s_ff;
               chosen_ff <= u_ff;
               nx_ff     <= nxa_ff;
               ny_ff     <= nya_ff;
               u_ff      <= u_ff + PW'(step_eff);
            end
         end
         default: begin
         end
      endcase
   end

   assign hit    = have_ff && (best_ff != '0);
   assign chosen = chosen_ff;
   assign nx     = nx_ff;
   assign ny     = ny_ff;
   assign den    = best_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb_spot_box_search_centroid.sv =====
`timescale 1ns / 1ps

module tb_spot_box_search_centroid;

   localparam int COLS = 2048;
   localparam int ROWS = 2048;
   localparam int STALL_LIMIT = 5000000;
   localparam int RANDOM_ITEMS = 1350;
   localparam logic [sbsc_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct {
      logic [7:0]        pixel;
      bit                eof;
      bit                typed;
      sbsc_pkg::rsp_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   sbsc_pkg::req_type req_data = '0;
   logic rsp_valid;
   sbsc_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [sbsc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sbsc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   sbsc_pkg::cfg_type shadow_cfg;
   longint unsigned col_weight[COLS];
   longint unsigned col_moment[COLS];
   int row_cnt;
   int col_cnt;
   sbsc_pkg::rsp_type spot_queue[$];
   int mismatches = 0;
   int stall_cycles = 0;
   int items_sent = 0;
   bit idling_on = 1'b1;
   stim_row_type dir_table[$];

   spot_box_search_centroid DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic void clear_columns();
      for (int i = 0; i < COLS; i++) begin
         col_weight[i] = 0;
         col_moment[i] = 0;
      end
      row_cnt = 0;
      col_cnt = 0;
   endfunction

   function automatic sbsc_pkg::rsp_type locate_spot();
      sbsc_pkg::rsp_type r;
      longint unsigned fwe, stp, best, s, chosen, nx, ny, den, u;
      bit have;
      r = '0;
      fwe = shadow_cfg.frame_width;
      if (fwe == 0) fwe = 1;
      if (fwe > COLS) fwe = COLS;
      stp = (shadow_cfg.scan_step == 0) ? 1 : shadow_cfg.scan_step;
      best = 0;
      chosen = 0;
      have = 0;
      nx = 0;
      ny = 0;
      den = 0;
      for (u = shadow_cfg.box_left; u + shadow_cfg.box_width < fwe; u += stp) begin
         s = 0;
         for (int c = 0; c < shadow_cfg.box_width; c++)
            if (u + c < COLS) s += col_weight[u + c];
         if (s < best) break;
         best = s;
         chosen = u;
         have = 1;
      end
      if (!have) return r;
      for (int c = 0; c < shadow_cfg.box_width; c++) begin
         if (chosen + c >= COLS) break;
         nx += c * col_weight[chosen + c];
         ny += col_moment[chosen + c];
         den += col_weight[chosen + c];
      end
      if (den == 0) return r;
      r.found = 1'b1;
      r.spot_x = 11'((chosen + nx / den) & 'h7FF);
      r.spot_y = 11'((shadow_cfg.box_top + ny / den) & 'h7FF);
      return r;
   endfunction

   function automatic void accumulate_pixel(logic [7:0] pix, bit eof, bit typed,
                                            sbsc_pkg::rsp_type want);
      longint unsigned p, fwe;
      p = (pix > shadow_cfg.pixel_threshold) ? pix : 0;
      fwe = shadow_cfg.frame_width;
      if (fwe == 0) fwe = 1;
      if (fwe > COLS) fwe = COLS;
      if (row_cnt < ROWS && col_cnt < COLS && row_cnt >= shadow_cfg.box_top &&
          row_cnt < shadow_cfg.box_top + shadow_cfg.box_height) begin
         col_weight[col_cnt] += p;
         col_moment[col_cnt] += (row_cnt - shadow_cfg.box_top) * p;
      end
      if (col_cnt + 1 >= fwe) begin
         col_cnt = 0;
         if (row_cnt < ROWS) row_cnt++;
      end else begin
         col_cnt++;
      end
      if (eof) begin
         spot_queue.push_back(typed ? want : locate_spot());
         clear_columns();
      end
   endfunction

   task automatic send_pixel(logic [7:0] pix, bit eof, bit typed, sbsc_pkg::rsp_type want);
      int gap;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= '{pixel: pix, end_of_frame: eof};
      do @(posedge clock); while (busy);
      accumulate_pixel(pix, eof, typed, want);
      items_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (spot_queue.size() != 0) @(negedge clock);
      @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_reg(logic [sbsc_pkg::CSR_IDX_W-1:0] idx,
                            logic [sbsc_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         sbsc_pkg::CSR_PIXEL_THRESHOLD: shadow_cfg.pixel_threshold = val[7:0];
         sbsc_pkg::CSR_FRAME_WIDTH:     shadow_cfg.frame_width = val;
         sbsc_pkg::CSR_BOX_LEFT:        shadow_cfg.box_left = val[10:0];
         sbsc_pkg::CSR_BOX_TOP:         shadow_cfg.box_top = val[10:0];
         sbsc_pkg::CSR_BOX_WIDTH:       shadow_cfg.box_width = val;
         sbsc_pkg::CSR_BOX_HEIGHT:      shadow_cfg.box_height = val;
         sbsc_pkg::CSR_SCAN_STEP:       shadow_cfg.scan_step = val;
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_frame(int n_pix, int bright);
      logic [7:0] pix;
      for (int i = 0; i < n_pix; i++) begin
         pix = ($urandom_range(0, 99) < bright) ? 8'($urandom_range(0, 255)) : 8'd0;
         send_pixel(pix, i == n_pix - 1, 1'b0, '0);
      end
      settle();
   endtask

   function automatic logic [sbsc_pkg::CSR_DATA_W-1:0] pick(int lo, int hi, int top);
      case ($urandom_range(0, 9))
         0: return sbsc_pkg::CSR_DATA_W'(lo);
         1: return sbsc_pkg::CSR_DATA_W'(top);
         2: return sbsc_pkg::CSR_DATA_W'($urandom);
         default: return sbsc_pkg::CSR_DATA_W'($urandom_range(lo, hi));
      endcase
   endfunction

   task automatic random_setup();
      int fw;
      fw = $urandom_range(1, 40);
      write_reg(sbsc_pkg::CSR_PIXEL_THRESHOLD, pick(0, 255, 255));
      write_reg(sbsc_pkg::CSR_FRAME_WIDTH,
                ($urandom_range(0, 9) == 0) ? pick(0, 2048, 4095)
                                            : sbsc_pkg::CSR_DATA_W'(fw));
      write_reg(sbsc_pkg::CSR_BOX_LEFT, pick(0, fw / 2, 2047));
      write_reg(sbsc_pkg::CSR_BOX_TOP, pick(0, 3, 2047));
      write_reg(sbsc_pkg::CSR_BOX_WIDTH, pick(0, fw, 4095));
      write_reg(sbsc_pkg::CSR_BOX_HEIGHT, pick(1, 6, 4095));
      write_reg(sbsc_pkg::CSR_SCAN_STEP, pick(0, 6, 4095));
      end_writes();
   endtask

   always @(posedge clock) begin
      sbsc_pkg::rsp_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_spot_box_search_centroid NOT OK");
            $finish;
         end
         if (rsp_valid) begin
            if (spot_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result transfer %p", rsp_data);
            end else begin
               want = spot_queue.pop_front();
               if (rsp_data.found !== want.found || rsp_data.spot_x !== want.spot_x ||
                   rsp_data.spot_y !== want.spot_y) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected found=%0d x=%0d y=%0d, got %0d %0d %0d",
                              want.found, want.spot_x, want.spot_y, rsp_data.found,
                              rsp_data.spot_x, rsp_data.spot_y);
               end
            end
         end
      end
   end

   initial begin
      shadow_cfg = '{pixel_threshold: sbsc_pkg::RST_PIXEL_THRESHOLD,
                     frame_width: sbsc_pkg::RST_FRAME_WIDTH,
                     box_left: sbsc_pkg::RST_BOX_LEFT, box_top: sbsc_pkg::RST_BOX_TOP,
                     box_width: sbsc_pkg::RST_BOX_WIDTH,
                     box_height: sbsc_pkg::RST_BOX_HEIGHT,
                     scan_step: sbsc_pkg::RST_SCAN_STEP};
      clear_columns();
      dir_table = '{
         '{8'd255, 1'b1, 1'b1, '{1'b1, 11'd0, 11'd0}},
         '{8'd200, 1'b1, 1'b1, '{1'b0, 11'd0, 11'd0}},
         '{8'd201, 1'b1, 1'b1, '{1'b1, 11'd0, 11'd0}},
         '{8'd0,   1'b1, 1'b1, '{1'b0, 11'd0, 11'd0}},
         '{8'd255, 1'b0, 1'b0, '0},
         '{8'd128, 1'b0, 1'b0, '0},
         '{8'd254, 1'b1, 1'b0, '0}
      };
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         send_pixel(dir_table[i].pixel, dir_table[i].eof, dir_table[i].typed,
                    dir_table[i].want);
         if (dir_table[i].eof) settle();
      end

      // Small frame, then frame width zero, then beyond the column memory, then a box at row 2047.
      write_reg(sbsc_pkg::CSR_PIXEL_THRESHOLD, 12'd0);
      write_reg(sbsc_pkg::CSR_FRAME_WIDTH, 12'd8);
      write_reg(sbsc_pkg::CSR_BOX_LEFT, 12'd0);
      write_reg(sbsc_pkg::CSR_BOX_TOP, 12'd1);
      write_reg(sbsc_pkg::CSR_BOX_WIDTH, 12'd3);
      write_reg(sbsc_pkg::CSR_BOX_HEIGHT, 12'd2);
      write_reg(sbsc_pkg::CSR_SCAN_STEP, 12'd0);
      write_reg(CSR_UNUSED, 12'hFFF);
      end_writes();
      run_frame(24, 90);
      write_reg(sbsc_pkg::CSR_FRAME_WIDTH, 12'd0);
      end_writes();
      run_frame(5, 90);
      write_reg(sbsc_pkg::CSR_FRAME_WIDTH, 12'hFFF);
      write_reg(sbsc_pkg::CSR_BOX_WIDTH, 12'd0);
      write_reg(sbsc_pkg::CSR_PIXEL_THRESHOLD, 12'd255);
      end_writes();
      run_frame(6, 100);
      write_reg(sbsc_pkg::CSR_PIXEL_THRESHOLD, 12'd254);
      write_reg(sbsc_pkg::CSR_FRAME_WIDTH, 12'd6);
      write_reg(sbsc_pkg::CSR_BOX_WIDTH, 12'd2);
      write_reg(sbsc_pkg::CSR_BOX_TOP, 12'd2047);
      write_reg(sbsc_pkg::CSR_SCAN_STEP, 12'hFFF);
      end_writes();
      run_frame(18, 100);

      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent > RANDOM_ITEMS * 4 / 5) idling_on = 1'b0;
         random_setup();
         run_frame($urandom_range(1, 60), $urandom_range(20, 100));
      end

      while (spot_queue.size() != 0) @(posedge clock);
      repeat (2200) @(posedge clock);
      if (mismatches == 0 && spot_queue.size() == 0)
         $display("tb_spot_box_search_centroid OK");
      else
         $display("tb_spot_box_search_centroid NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sbsc_pkg.sv
rtl/sbsc_colmem.sv
rtl/sbsc_div.sv
rtl/sbsc_search.sv
rtl/spot_box_search_centroid.sv
tb/sv/tb_spot_box_search_centroid.sv
